// ===== src/sha256_pkg.sv =====
// Package for the SHA-256 message hasher: round constants, initial hash and helpers.
// Used by every module of the hasher; depends on nothing.
package sha256_pkg;

    localparam int WordW = 32;
    localparam int IdxW = 3;
    localparam int CountW = 61;
    localparam int QueueDepth = 4;

    localparam logic [7:0] PadByte = 8'h80;

    // One block handed from the front end to the compression engine.
    typedef struct packed {
        logic [511:0] block;
        logic         final_block;
    } blk_item_t;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] r;
        case (i)
            6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
            6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
            6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
            6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== src/sha256_front.sv =====
// Front end: packs message bytes into 64-byte blocks, counts length and pads.
// Depends on sha256_pkg; feeds blocks to the block queue.
module sha256_front
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] data_byte,
    input  logic      byte_present,
    input  logic      end_of_message,
    output logic      blk_valid,
    input  logic      blk_ready,
    output blk_item_t blk_item
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StPad  = 2'd1;
    localparam logic [1:0] StSend = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [511:0]      buf_reg, buf_next;
    logic [5:0]        pos_reg, pos_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              pend_final_reg, pend_final_next;
    logic              padding_reg, padding_next;
    logic [1:0]        after_reg, after_next;

    logic [7:0]  wr_byte;
    logic        wr_en;
    logic [63:0] bit_len;

    assign in_ready = (state_reg == StIdle);
    assign blk_valid = (state_reg == StSend);
    assign blk_item.block = buf_reg;
    assign blk_item.final_block = pend_final_reg;
    assign bit_len = {count_reg, 3'b000};

    always_comb
    begin
        state_next = state_reg;
        buf_next = buf_reg;
        pos_next = pos_reg;
        count_next = count_reg;
        pend_final_next = pend_final_reg;
        padding_next = padding_reg;
        after_next = after_reg;
        wr_en = 1'b0;
        wr_byte = 8'h00;
        case (state_reg)
            StIdle:
            begin
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        wr_en = 1'b1;
                        wr_byte = data_byte;
                        count_next = count_reg + 1'b1;
                    end
                    padding_next = end_of_message;
                    // Queue the pad marker after the byte, or at once if no byte came.
                    if (end_of_message && !byte_present)
                    begin
                        wr_en = 1'b1;
                        wr_byte = PadByte;
                        padding_next = 1'b0;
                        state_next = StPad;
                    end
                    if (wr_en && pos_reg == 6'd63)
                    begin
                        pend_final_next = 1'b0;
                        after_next = end_of_message ? StPad : StIdle;
                        if (end_of_message && byte_present)
                        begin
                            padding_next = 1'b1;
                        end
                        state_next = StSend;
                    end
                    else if (end_of_message && byte_present)
                    begin
                        state_next = StPad;
                    end
                end
            end
            StPad:
            begin
                wr_en = 1'b1;
                wr_byte = padding_reg ? PadByte : 8'h00;
                padding_next = 1'b0;
                if (!padding_reg && pos_reg == 6'd56)
                begin
                    wr_en = 1'b0;
                    buf_next[63:0] = bit_len;
                    pend_final_next = 1'b1;
                    after_next = StIdle;
                    state_next = StSend;
                end
                else if (pos_reg == 6'd63)
                begin
                    pend_final_next = 1'b0;
                    after_next = StPad;
                    state_next = StSend;
                end
            end
            StSend:
            begin
                if (blk_ready)
                begin
                    state_next = after_reg;
                    pos_next = 6'd0;
                    if (pend_final_reg)
                    begin
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
        if (wr_en)
        begin
            buf_next[511 - 8*pos_reg -: 8] = wr_byte;
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            pos_reg <= '0;
            count_reg <= '0;
            pend_final_reg <= 1'b0;
            padding_reg <= 1'b0;
            after_reg <= StIdle;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            count_reg <= count_next;
            pend_final_reg <= pend_final_next;
            padding_reg <= padding_next;
            after_reg <= after_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ===== src/sha256_queue.sv =====
// Short block queue between the front end and the compression engine.
// Depends on sha256_pkg for the block item type.
module sha256_queue
    import sha256_pkg::*;
#(
    parameter int Depth = QueueDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  blk_item_t wr_item,
    output logic      rd_valid,
    input  logic      rd_ready,
    output blk_item_t rd_item
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    blk_item_t        mem [Depth];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             push, pop;

    assign wr_ready = (cnt_reg != Depth[AW:0]);
    assign rd_valid = (cnt_reg != '0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_item = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
        end
    end

endmodule

// ===== src/sha256_core.sv =====
// Compression engine: one SHA-256 round per cycle, then digest word output after a final block.
// Depends on sha256_pkg; takes blocks from the queue and drives the result stream.
module sha256_core
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        blk_valid,
    output logic        blk_ready,
    input  blk_item_t   blk_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word,
    output logic [2:0]  out_index,
    output logic        out_last
);

    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StRound = 2'd1;
    localparam logic [1:0] StAdd   = 2'd2;
    localparam logic [1:0] StOut   = 2'd3;

    logic [1:0]  state_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  oidx_reg;
    logic        final_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];

    logic [31:0] a, e, s0, s1, b0, b1, ch, mj, t1, t2, wnew;

    // The schedule window shifts by one word per round; w_reg[0] is this round's word.
    always_comb
    begin
        a = v_reg[0];
        e = v_reg[4];
        b1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch = (e & v_reg[5]) ^ (~e & v_reg[6]);
        t1 = v_reg[7] + b1 + ch + round_k(rnd_reg) + w_reg[0];
        b0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        mj = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = b0 + mj;
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
    end

    assign blk_ready = (state_reg == StIdle);
    assign out_valid = (state_reg == StOut);
    assign out_word = h_reg[oidx_reg];
    assign out_index = oidx_reg;
    assign out_last = (oidx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            rnd_reg <= '0;
            oidx_reg <= '0;
            final_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            case (state_reg)
                StIdle:
                begin
                    if (blk_valid)
                    begin
                        final_reg <= blk_item.final_block;
                        rnd_reg <= '0;
                        state_reg <= StRound;
                    end
                end
                StRound:
                begin
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= StAdd;
                    end
                end
                StAdd:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    oidx_reg <= '0;
                    state_reg <= final_reg ? StOut : StIdle;
                end
                StOut:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 1'b1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= init_hash(3'(i));
                            end
                            state_reg <= StIdle;
                        end
                    end
                end
                default:
                begin
                    state_reg <= StIdle;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == StIdle && blk_valid)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= blk_item.block[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == StRound)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

// ===== src/sha256_message_hasher_top.sv =====
// Top level of the SHA-256 message hasher: front end, block queue, compression engine.
// Depends on sha256_pkg, sha256_front, sha256_queue and sha256_core.
//
// Channel | Direction | tdata fields (low bit up)     | tuser / tlast
// s_axis  | in        | data_byte[7:0]                | tuser: byte_present, tlast: end_of_message
// m_axis  | out       | digest_word[31:0]             | tuser: word_index[2:0], tlast: last_word
//
// Byte words are taken while the front end is idle; a full block waits in the queue and
// the engine runs it one round a cycle. The front end holds off input while it hands a
// block to the queue, for as long as the queue is full, and throughout padding. An end marker
// costs a padding pass plus one or two compressions, then eight result words. Reset is
// asynchronous, active low.
module sha256_message_hasher_top
    import sha256_pkg::*;
#(
    parameter int QDepth = QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word[31:0]
    output logic [2:0]  m_axis_tuser,   // word_index[2:0]
    output logic        m_axis_tlast
);

    logic      f_valid, f_ready, c_valid, c_ready;
    blk_item_t f_item, c_item;

    sha256_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .data_byte(s_axis_tdata), .byte_present(s_axis_tuser),
        .end_of_message(s_axis_tlast),
        .blk_valid(f_valid), .blk_ready(f_ready), .blk_item(f_item)
    );

    sha256_queue #(.Depth(QDepth)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(c_valid), .rd_ready(c_ready), .rd_item(c_item)
    );

    sha256_core u_core (
        .clk(clk), .rst_n(rst_n),
        .blk_valid(c_valid), .blk_ready(c_ready), .blk_item(c_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_word(m_axis_tdata), .out_index(m_axis_tuser), .out_last(m_axis_tlast)
    );

endmodule

// ===== verif/sha256_checker.sv =====
// Checker for the SHA-256 message hasher: watches both stream channels, predicts digests.
// Depends on nothing beyond the ports of sha256_message_hasher_top.
`timescale 1ns / 1ps
module sha256_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // digest_word[31:0]
    input  logic [2:0]  m_axis_tuser,   // word_index[2:0]
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending,
    output int          words_checked,
    output int          messages
);

    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] HashStart [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]  run_hash [8];
    logic [7:0]   block_bytes [64];
    int           fill;
    logic [60:0]  byte_count;
    digest_word_t digest_q [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = run_hash[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            run_hash[i] = run_hash[i] + v[i];
    endfunction

    function automatic void absorb(input logic [7:0] b);
        block_bytes[fill] = b;
        fill++;
        if (fill == 64)
        begin
            compress();
            fill = 0;
        end
    endfunction

    // Pads the message, appends the bit length and queues the eight digest words.
    function automatic void finish_message();
        logic [63:0] bit_len;
        bit_len = {byte_count, 3'b000};
        absorb(8'h80);
        if (fill > 56)
            while (fill != 0)
                absorb(8'h00);
        while (fill < 56)
            absorb(8'h00);
        for (int i = 0; i < 8; i++)
            absorb(bit_len[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++)
            digest_q.push_back('{run_hash[i], i[2:0], i == 7});
        run_hash = HashStart;
        byte_count = '0;
        messages++;
    endfunction

    initial
    begin
        run_hash = HashStart;
        fill = 0;
        byte_count = '0;
        errors = 0;
        words_checked = 0;
        messages = 0;
    end

    assign pending = digest_q.size();

    always @(posedge clk)
    begin
        digest_word_t exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                exp_w = digest_q.pop_front();
                words_checked++;
                if (m_axis_tdata !== exp_w.digest || m_axis_tuser !== exp_w.idx
                    || m_axis_tlast !== exp_w.last)
                begin
                    errors++;
                    $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
                             $time, exp_w.digest, exp_w.idx, exp_w.last,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (s_axis_tuser)
            begin
                absorb(s_axis_tdata);
                byte_count = byte_count + 1'b1;
            end
            if (s_axis_tlast)
                finish_message();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the SHA-256 message hasher: clock, reset, byte stimulus and verdict.
// Depends on sha256_message_hasher_top and sha256_checker.
`timescale 1ns / 1ps
module tb;

    localparam int IdleLimit = 4000;
    localparam int ItemGoal = 380;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    int          errors, pending, words_checked, messages;
    int          items;
    bit          calm;
    bit          long_hold;
    int          idle_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sha256_message_hasher_top u_top (.*);

    sha256_checker u_chk (.*);

    // One word on the input channel; returns after acceptance and any random pause.
    task automatic put_word(input logic [7:0] d, input logic present, input logic last);
        s_axis_tdata  <= d;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        if (present || last)
            items++;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // A message of len bytes, ended either on its last byte or by a bare end marker.
    task automatic send_message(input int len, input bit bare_end);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                put_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            put_word(8'($urandom_range(0, 255)), 1'b1, !bare_end && i == len - 1);
        end
        if (bare_end || len == 0)
            put_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int len;
        int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        bit held;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        items = 0;
        held = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message, an idle word, then short messages of extreme bytes.
        put_word(8'h5a, 1'b0, 1'b1);
        put_word(8'hff, 1'b0, 1'b0);
        put_word(8'hff, 1'b1, 1'b1);
        put_word(8'h00, 1'b1, 1'b0);
        put_word(8'hff, 1'b1, 1'b0);
        put_word(8'h00, 1'b0, 1'b1);
        put_word(8'h00, 1'b1, 1'b1);

        while (items < ItemGoal)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: len = $urandom_range(0, 8);
                3:       len = edges[$urandom_range(0, 7)];
                default: len = $urandom_range(0, 30);
            endcase
            if (!held && items > 120)
            begin
                long_hold = 1;
                held = 1;
            end
            if (items > ItemGoal - 50)
                calm = 1;
            send_message(len, 1'($urandom_range(0, 1)));
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Hashed %0d messages from %0d input items; %0d digest words checked.",
                 messages, items, words_checked);
        if (errors == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off that backs up the block queue.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (800) @(posedge clk);
                long_hold = 0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Watchdog: no word moved for %0d cycles.", IdleLimit);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule
